### hw/rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants for the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int MAX_POINTS_DEF = 64;

  localparam int VAL_W  = 32;
  localparam int DIFF_W = VAL_W + 1;       // difference of two Q16.16 values
  localparam int PROD_W = 2 * DIFF_W;      // exact product of two differences
  localparam int QEXT_W = PROD_W + 2;      // rounded quotient magnitude
  localparam int SUM_W  = QEXT_W + 1;      // y1 plus quotient

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] ST_INTERP = 2'd0;
  localparam logic [1:0] ST_EXTRAP = 2'd1;
  localparam logic [1:0] ST_FEW    = 2'd2;
  localparam logic [1:0] ST_ZEROW  = 2'd3;

  typedef struct packed {
    logic signed [VAL_W-1:0] w;
    logic                    del;
  } pli_query_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_RD,
    BK_CMP,
    BK_RDA,
    BK_RDB,
    BK_GETB,
    BK_CHK,
    BK_MUL,
    BK_DIV,
    BK_RND,
    BK_FIN,
    BK_OUT
  } pli_back_state_t;

endpackage

### hw/rtl/pli_in_if.sv
// ----------------------------------------------------------------------------
// pli_in_if
// Input channel: action with point or query payload.
// ----------------------------------------------------------------------------
interface pli_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic               deleted_in;

  modport source (output valid, action, x_value, y_value, deleted_in, input ready);
  modport sink   (input valid, action, x_value, y_value, deleted_in, output ready);
endinterface

### hw/rtl/pli_out_if.sv
// ----------------------------------------------------------------------------
// pli_out_if
// Output channel: interpolation result.
// ----------------------------------------------------------------------------
interface pli_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               deleted_out;
  logic [1:0]         status;

  modport source (output valid, result_value, deleted_out, status, input ready);
  modport sink   (input valid, result_value, deleted_out, status, output ready);
endinterface

### hw/rtl/pli_ram.sv
// ----------------------------------------------------------------------------
// pli_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/pli_front.sv
// ----------------------------------------------------------------------------
// pli_front
// Accepts items, maintains the point table and count, queues queries.
// ----------------------------------------------------------------------------
module pli_front import pli_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  localparam int IDX_W = $clog2(MAX_POINTS),
  localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  pli_in_if.sink                in_ch,
  output logic                  we,
  output logic [IDX_W-1:0]      waddr,
  output logic [2*VAL_W-1:0]    wdata,
  output logic [CNT_W-1:0]      count,
  output logic                  q_valid,
  output pli_query_t            q_data,
  input  logic                  q_pop,
  input  logic                  back_busy
);
  pli_query_t ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_cnt;
  logic       take;
  logic       push;

  // Table updates wait until no query is pending, so a scan sees a stable table.
  always_comb begin
    if (in_ch.action == ACT_QUERY) begin
      in_ch.ready = (q_cnt != 2'd2);
    end else begin
      in_ch.ready = (q_cnt == 2'd0) && !back_busy;
    end
  end

  assign take  = in_ch.valid && in_ch.ready;
  assign push  = take && (in_ch.action == ACT_QUERY);
  assign we    = take && (in_ch.action == ACT_APPEND) && !in_ch.deleted_in &&
                 (count < CNT_W'(MAX_POINTS));
  assign waddr = count[IDX_W-1:0];
  assign wdata = {in_ch.x_value, in_ch.y_value};

  assign q_valid = (q_cnt != 2'd0);
  assign q_data  = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_cnt  <= '0;
    end else begin
      if (take && in_ch.action == ACT_CLEAR) begin
        count <= '0;
      end else if (we) begin
        count <= count + 1'b1;
      end
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      q_cnt <= q_cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= '{w: in_ch.x_value, del: in_ch.deleted_in};
    end
  end
endmodule

### hw/rtl/pli_back.sv
// ----------------------------------------------------------------------------
// pli_back
// Scans the table, forms the segment quotient bit-serially, drives results.
// ----------------------------------------------------------------------------
module pli_back import pli_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  localparam int IDX_W = $clog2(MAX_POINTS),
  localparam int CNT_W = $clog2(MAX_POINTS + 1),
  localparam int DC_W  = $clog2(PROD_W + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [CNT_W-1:0]   count,
  input  logic               q_valid,
  input  pli_query_t         q_data,
  output logic               q_pop,
  output logic [IDX_W-1:0]   raddr,
  input  logic [2*VAL_W-1:0] rdata,
  output logic               busy,
  pli_out_if.source          out_ch
);
  pli_back_state_t state, state_next;

  logic signed [VAL_W-1:0] w;
  logic [CNT_W-1:0]        j;
  logic [IDX_W-1:0]        ia, ib;
  logic [1:0]              st;
  logic signed [VAL_W-1:0] x1, y1, x2, y2;
  logic [DIFF_W-1:0]       mdy, mdw, mdx;
  logic                    neg;
  logic [PROD_W-1:0]       dvd;
  logic [DIFF_W-1:0]       rem;
  logic [DC_W-1:0]         dcnt;
  logic [QEXT_W-1:0]       qmag;
  logic signed [VAL_W-1:0] res;
  logic                    res_del;

  logic signed [VAL_W-1:0]  rx, ry;
  logic signed [DIFF_W-1:0] dy, dw, dx;
  logic [DIFF_W:0]          rem_sh;
  logic                     ge;
  logic signed [SUM_W-1:0]  sq, sum;

  assign rx = rdata[2*VAL_W-1:VAL_W];
  assign ry = rdata[VAL_W-1:0];
  assign dy = DIFF_W'(y2) - DIFF_W'(y1);
  assign dw = DIFF_W'(w) - DIFF_W'(x1);
  assign dx = DIFF_W'(x2) - DIFF_W'(x1);
  assign rem_sh = {rem, dvd[PROD_W-1]};
  assign ge = rem_sh >= {1'b0, mdx};
  assign sq  = neg ? -SUM_W'(qmag) : SUM_W'(qmag);
  assign sum = SUM_W'(y1) + sq;

  assign busy  = (state != BK_IDLE);
  assign q_pop = (state == BK_IDLE) && q_valid;

  always_comb begin
    state_next = state;
    raddr      = j[IDX_W-1:0];
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_data.del || count < CNT_W'(2)) begin
            state_next = BK_OUT;
          end else begin
            state_next = BK_RD;
          end
        end
      end
      BK_RD:   state_next = BK_CMP;
      BK_CMP: begin
        if (rx > w || j + 1'b1 == count) begin
          state_next = BK_RDA;
        end else begin
          state_next = BK_RD;
        end
      end
      BK_RDA: begin
        raddr      = ia;
        state_next = BK_RDB;
      end
      BK_RDB: begin
        raddr      = ib;
        state_next = BK_GETB;
      end
      BK_GETB: state_next = BK_CHK;
      BK_CHK: begin
        if (y1 == y2 || x1 == x2) begin
          state_next = BK_OUT;
        end else begin
          state_next = BK_MUL;
        end
      end
      BK_MUL:  state_next = BK_DIV;
      BK_DIV: begin
        if (dcnt == DC_W'(1)) begin
          state_next = BK_RND;
        end
      end
      BK_RND:  state_next = BK_FIN;
      BK_FIN:  state_next = BK_OUT;
      BK_OUT: begin
        if (!out_ch.valid || out_ch.ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_OUT && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        w       <= q_data.w;
        j       <= '0;
        st      <= ST_INTERP;
        res     <= '0;
        res_del <= q_data.del;
        if (!q_data.del && count < CNT_W'(2)) begin
          st <= ST_FEW;
        end
      end
      BK_CMP: begin
        if (rx > w) begin
          if (j == '0) begin
            ia <= '0;
            ib <= IDX_W'(1);
            st <= ST_EXTRAP;
          end else begin
            ia <= IDX_W'(j - 1'b1);
            ib <= j[IDX_W-1:0];
          end
        end else if (j + 1'b1 == count) begin
          // no stored x above w: last segment
          ia <= IDX_W'(count - CNT_W'(2));
          ib <= IDX_W'(count - 1'b1);
          st <= ST_EXTRAP;
        end else begin
          j <= j + 1'b1;
        end
      end
      BK_RDB: begin
        x1 <= rx;
        y1 <= ry;
      end
      BK_GETB: begin
        x2 <= rx;
        y2 <= ry;
      end
      BK_CHK: begin
        res <= y1;
        if (y1 != y2 && x1 == x2) begin
          st <= ST_ZEROW;
        end
        mdy <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        mdw <= dw[DIFF_W-1] ? DIFF_W'(-dw) : DIFF_W'(dw);
        mdx <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        neg <= dy[DIFF_W-1] ^ dw[DIFF_W-1] ^ dx[DIFF_W-1];
      end
      BK_MUL: begin
        dvd  <= mdy * mdw;
        rem  <= '0;
        dcnt <= DC_W'(PROD_W);
      end
      BK_DIV: begin
        // restoring division, one quotient bit per cycle
        rem  <= ge ? DIFF_W'(rem_sh - {1'b0, mdx}) : DIFF_W'(rem_sh);
        dvd  <= {dvd[PROD_W-2:0], ge};
        dcnt <= dcnt - 1'b1;
      end
      BK_RND: begin
        qmag <= QEXT_W'(dvd) + QEXT_W'(({rem, 1'b0} >= {1'b0, mdx}));
      end
      BK_FIN: begin
        if (sum > SUM_W'(32'sh7fffffff)) begin
          res <= 32'sh7fffffff;
        end else if (sum < -SUM_W'(33'sh080000000)) begin
          res <= 32'sh80000000;
        end else begin
          res <= sum[VAL_W-1:0];
        end
      end
      BK_OUT: begin
        if (!out_ch.valid || out_ch.ready) begin
          out_ch.result_value <= res;
          out_ch.deleted_out  <= res_del;
          out_ch.status       <= st;
        end
      end
      default: ;
    endcase
  end
endmodule

### hw/rtl/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Q16.16 breakpoint table with interpolating and extrapolating queries.
// ----------------------------------------------------------------------------
// Usage: in_ch carries clear, append and query transactions; out_ch returns
// one transaction per query (result, deleted flag, status). Clear and append
// produce nothing. An append that is not deleted and finds the table not full
// writes the point RAM in the accepting cycle. A query waits in a two-entry
// queue, then the back end scans the table point by point (RAM read,
// compare), reads the segment end points, forms the exact product in one
// multiply and divides with a restoring divider at one bit per cycle.
// Deleted queries and tables with fewer than two points skip the scan and
// the division and answer directly.
// Clear and append are held off while any query is queued or in work.
// Reset empties the table count and the queue; RAM contents are not
// cleared. If the receiver stalls, the finished result waits in the output
// register while the back end holds its next result; queries keep
// entering the queue until it is full.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator import pli_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pli_in_if.sink    in_ch,
  pli_out_if.source out_ch
);
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic               we;
  logic [IDX_W-1:0]   waddr, raddr;
  logic [2*VAL_W-1:0] wdata, rdata;
  logic [CNT_W-1:0]   count;
  logic               q_valid, q_pop, back_busy;
  pli_query_t         q_data;

  pli_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk, .rst, .in_ch, .we, .waddr, .wdata, .count,
    .q_valid, .q_data, .q_pop, .back_busy
  );

  pli_ram #(.WIDTH(2 * VAL_W), .DEPTH(MAX_POINTS)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  pli_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk, .rst, .count, .q_valid, .q_data, .q_pop, .raddr, .rdata,
    .busy(back_busy), .out_ch
  );

  a_tbl_stable: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.action != ACT_QUERY) |-> !back_busy)
    else $error("table update during query work");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty query queue");

  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("result valid after reset");
endmodule
